[rtl/mrg_pkg.sv]
package mrg_pkg;

  // Field widths.
  localparam int unsigned WordW = 32;
  localparam int unsigned ActW  = 3;
  localparam int unsigned CntW  = 5;
  localparam int unsigned RemW  = 17;
  localparam int unsigned QuoW  = 15;

  // Action codes.
  localparam logic [ActW-1:0] ACT_SEED_NZ  = 3'd0;
  localparam logic [ActW-1:0] ACT_SEED     = 3'd1;
  localparam logic [ActW-1:0] ACT_RAW      = 3'd2;
  localparam logic [ActW-1:0] ACT_BOUND    = 3'd3;
  localparam logic [ActW-1:0] ACT_RANGE    = 3'd4;

  // Generator constants.
  localparam logic [WordW-1:0] SEED_SUBST = 32'd123459876;
  localparam logic [WordW-1:0] SCHRAGE_Q  = 32'd127773;
  localparam logic [14:0]      SCHRAGE_A  = 15'd16807;
  localparam logic [11:0]      SCHRAGE_R  = 12'd2836;
  localparam logic [WordW:0]   MODULUS_M  = 33'h0_7FFF_FFFF;

  // Last count of a bit-serial division pass.
  localparam logic [CntW-1:0]  CNT_LAST   = 5'd31;

  // Sequencer states.
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SDIV = 9'b000000010,
    S_MULA = 9'b000000100,
    S_MULB = 9'b000001000,
    S_COMB = 9'b000010000,
    S_FIX  = 9'b000100000,
    S_MDIV = 9'b001000000,
    S_ADD  = 9'b010000000,
    S_FIN  = 9'b100000000
  } mrg_state_t;

endpackage

[rtl/minimal_standard_random_generator.sv]
// Sequence: a seed request takes effect at its accept edge; a draw runs S_SDIV, S_MULA, S_MULB,
// S_COMB and S_FIX, a bounded or range draw then S_MDIV and S_ADD, and S_FIN loads the output
// register (a zero bound or empty range goes straight there); S_FIN waits out any output stall.
// No new request is taken until the state is back in S_IDLE; the shared bit-serial divider (one
// quotient bit per cycle) runs once for the Schrage split and once more for the bound reduction.
// Reset: synchronous, active low; the seed word clears to zero and no result is pending.
module minimal_standard_random_generator
  import mrg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ActW-1:0]         in_action,
  input  logic [WordW-1:0]        in_seed_value,
  input  logic [WordW-1:0]        in_upper_limit,
  input  logic signed [WordW-1:0] in_lower_limit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WordW-1:0] out_value
);

  mrg_state_t       state_r, state_nxt;
  logic [WordW-1:0] rng_r, rng_nxt;
  logic [ActW-1:0]  act_r, act_nxt;
  logic [WordW-1:0] bound_r, bound_nxt;
  logic [WordW-1:0] lower_r, lower_nxt;
  logic             neg_r, neg_nxt;
  logic [WordW-1:0] rem_r, rem_nxt;
  logic [WordW-1:0] dq_r, dq_nxt;
  logic [WordW-1:0] div_r, div_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [WordW-1:0] p1_r, p1_nxt;
  logic [26:0]      p2_r, p2_nxt;
  logic [WordW:0]   t_r, t_nxt;
  logic [WordW-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_value_r, out_value_nxt;

  logic             accept;
  logic             out_free;
  logic [WordW-1:0] x_seed;
  logic [WordW:0]   trial;
  logic [WordW:0]   trial_diff;
  logic             trial_ge;
  logic [WordW:0]   fixed;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // A zero seed word is replaced before the step.
  assign x_seed = (rng_r == '0) ? SEED_SUBST : rng_r;

  // One restoring division step: shift in the next dividend bit and try the subtract.
  assign trial      = {rem_r, dq_r[WordW-1]};
  assign trial_diff = trial - {1'b0, div_r};
  assign trial_ge   = (trial >= {1'b0, div_r});

  // Fold a negative step result back into the modulus range.
  assign fixed = t_r[WordW] ? (t_r + MODULUS_M) : t_r;

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    rng_nxt       = rng_r;
    act_nxt       = act_r;
    bound_nxt     = bound_r;
    lower_nxt     = lower_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    t_nxt         = t_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          lower_nxt = in_lower_limit;
          bound_nxt = (in_action == ACT_RANGE) ? (in_upper_limit - in_lower_limit)
                                               : in_upper_limit;
          // Set up the Schrage split of the magnitude of the seed word.
          neg_nxt = x_seed[WordW-1];
          dq_nxt  = x_seed[WordW-1] ? (~x_seed + 32'd1) : x_seed;
          rem_nxt = '0;
          div_nxt = SCHRAGE_Q;
          cnt_nxt = '0;
          unique case (in_action)
            ACT_SEED_NZ: begin
              if (in_seed_value != '0) begin
                rng_nxt = in_seed_value;
              end
            end
            ACT_SEED: begin
              rng_nxt = in_seed_value;
            end
            ACT_RAW: begin
              state_nxt = S_SDIV;
            end
            ACT_BOUND: begin
              if (in_upper_limit == '0) begin
                res_nxt   = '0;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_SDIV;
              end
            end
            ACT_RANGE: begin
              if (in_lower_limit >= $signed(in_upper_limit)) begin
                res_nxt   = in_lower_limit;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_SDIV;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SDIV, S_MDIV: begin
        if (trial_ge) begin
          rem_nxt = trial_diff[WordW-1:0];
        end else begin
          rem_nxt = trial[WordW-1:0];
        end
        dq_nxt  = {dq_r[WordW-2:0], trial_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = (state_r == S_SDIV) ? S_MULA : S_ADD;
        end
      end
      S_MULA: begin
        p1_nxt    = WordW'({17'd0, rem_r[RemW-1:0]} * {17'd0, SCHRAGE_A});
        state_nxt = S_MULB;
      end
      S_MULB: begin
        p2_nxt    = 27'({12'd0, dq_r[QuoW-1:0]} * {15'd0, SCHRAGE_R});
        state_nxt = S_COMB;
      end
      S_COMB: begin
        // The sign of the seed word flips both Schrage terms.
        if (neg_r) begin
          t_nxt = {6'd0, p2_r} - {1'b0, p1_r};
        end else begin
          t_nxt = {1'b0, p1_r} - {6'd0, p2_r};
        end
        state_nxt = S_FIX;
      end
      S_FIX: begin
        rng_nxt = fixed[WordW-1:0];
        res_nxt = fixed[WordW-1:0];
        // Reduce the draw by the bound in a second divider pass.
        dq_nxt  = fixed[WordW-1:0];
        rem_nxt = '0;
        div_nxt = bound_r;
        cnt_nxt = '0;
        state_nxt = (act_r == ACT_RAW) ? S_FIN : S_MDIV;
      end
      S_ADD: begin
        res_nxt   = (act_r == ACT_RANGE) ? (rem_r + lower_r) : rem_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rng_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rng_r       <= rng_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    bound_r     <= bound_nxt;
    lower_r     <= lower_nxt;
    neg_r       <= neg_nxt;
    rem_r       <= rem_nxt;
    dq_r        <= dq_nxt;
    div_r       <= div_nxt;
    cnt_r       <= cnt_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    t_r         <= t_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule
